// ===== src/tksr_pkg.sv =====
// Shared types and constants of the top-k score table.
// Used by the sequencer and the top level; no dependencies of its own.
package tksr_pkg;

    // Table geometry
    localparam int unsigned TABLE_DEPTH = 10;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int unsigned SCORE_W = 20;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned RANK_W  = 4;

    // Stream data widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 64;

    // Limits
    localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(999999);
    localparam int unsigned        RANK_MAX  = 15;

    // Last slot of the table
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);

    // One table entry as held in the RAM
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Access request from the sequencer to the table RAM
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
    } mem_req_t;

endpackage

// ===== src/tksr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the new data. No dependencies.
module tksr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read with write-first forwarding
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

endmodule

// ===== src/tksr_seq.sv =====
// Sequencer of the top-k score table: qualify check, exchange sort over the
// table RAM, ranking and table dump into the output register. Uses tksr_pkg.
module tksr_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tksr_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tksr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser,
    // Table RAM
    output tksr_pkg::mem_req_t                  mem_req,
    input  tksr_pkg::entry_t                    rd_data
);
    import tksr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_CMP,
        ST_WRITE,
        ST_DUMP
    } state_t;

    state_t             state_reg,      state_next;
    logic [SCORE_W-1:0] score_reg,      score_next;
    logic [TAG_W-1:0]   tag_reg,        tag_next;
    entry_t             cur_reg,        cur_next;
    logic [ADDR_W-1:0]  i_reg,          i_next;
    logic [ADDR_W-1:0]  j_reg,          j_next;
    logic [ADDR_W-1:0]  k_reg,          k_next;
    logic               pend_reg,       pend_next;
    logic               qual_reg,       qual_next;
    logic [SCORE_W-1:0] prev_score_reg, prev_score_next;
    logic [RANK_W-1:0]  prev_rank_reg,  prev_rank_next;

    // Output register
    logic               out_vld_reg,    out_vld_next;
    logic [INDEX_W-1:0] out_index_reg,  out_index_next;
    logic [SCORE_W-1:0] out_score_reg,  out_score_next;
    logic [TAG_W-1:0]   out_tag_reg,    out_tag_next;
    logic [RANK_W-1:0]  out_rank_reg,   out_rank_next;
    logic               out_qual_reg,   out_qual_next;
    logic               out_last_reg,   out_last_next;

    logic               out_free;
    logic [SCORE_W-1:0] in_score;
    logic [ADDR_W:0]    k_plus1;
    logic [RANK_W-1:0]  rank_pos;
    logic [RANK_W-1:0]  rank_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_vld_reg || m_tready;

    // Saturate the offered score
    assign in_score = (s_tdata[SCORE_W-1:0] > SCORE_MAX) ? SCORE_MAX : s_tdata[SCORE_W-1:0];

    // Competition rank of the slot being dumped: position-based when strictly
    // below the previous slot, otherwise shared with it
    assign k_plus1  = {1'b0, k_reg} + (ADDR_W+1)'(1);
    assign rank_pos = (32'(k_plus1) > 32'(RANK_MAX)) ? RANK_W'(RANK_MAX) : RANK_W'(k_plus1);
    assign rank_new = ((k_reg == '0) || (rd_data.score < prev_score_reg)) ?
                      rank_pos : prev_rank_reg;

    // Next-state logic and RAM requests
    always_comb
    begin
        state_next      = state_reg;
        score_next      = score_reg;
        tag_next        = tag_reg;
        cur_next        = cur_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        qual_next       = qual_reg;
        prev_score_next = prev_score_reg;
        prev_rank_next  = prev_rank_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_score_next  = out_score_reg;
        out_tag_next    = out_tag_reg;
        out_rank_next   = out_rank_reg;
        out_qual_next   = out_qual_reg;
        out_last_next   = out_last_reg;
        mem_req         = '0;

        case (state_reg)
            // Take a request and fetch the last slot
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    score_next    = in_score;
                    tag_next      = s_tdata[SCORE_W +: TAG_W];
                    mem_req.re    = 1'b1;
                    mem_req.raddr = LAST_SLOT;
                    state_next    = ST_CHECK;
                end
            end

            // Qualify against the last slot; replace it if at least equal
            ST_CHECK:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                if (score_reg >= rd_data.score)
                begin
                    qual_next     = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = LAST_SLOT;
                    mem_req.wdata = '{score: score_reg, tag: tag_reg};
                    i_next        = '0;
                    state_next    = ST_LOAD;
                end
                else
                begin
                    qual_next  = 1'b0;
                    k_next     = '0;
                    pend_next  = 1'b1;
                    state_next = ST_DUMP;
                end
            end

            // Hold slot i in a register for the pass
            ST_LOAD:
            begin
                cur_next      = rd_data;
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(i_reg + ADDR_W'(1));
                j_next        = ADDR_W'(i_reg + ADDR_W'(1));
                state_next    = ST_CMP;
            end

            // Compare held slot with slot j; exchange when held <= slot j
            ST_CMP:
            begin
                if (cur_reg.score <= rd_data.score)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = j_reg;
                    mem_req.wdata = cur_reg;
                    cur_next      = rd_data;
                end
                if (j_reg == LAST_SLOT)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ADDR_W'(j_reg + ADDR_W'(1));
                    j_next        = ADDR_W'(j_reg + ADDR_W'(1));
                end
            end

            // Put the pass winner into slot i; next pass or dump
            ST_WRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = cur_reg;
                mem_req.re    = 1'b1;
                if (i_reg == ADDR_W'(LAST_SLOT - ADDR_W'(1)))
                begin
                    mem_req.raddr = '0;
                    k_next        = '0;
                    pend_next     = 1'b1;
                    state_next    = ST_DUMP;
                end
                else
                begin
                    mem_req.raddr = ADDR_W'(i_reg + ADDR_W'(1));
                    i_next        = ADDR_W'(i_reg + ADDR_W'(1));
                    state_next    = ST_LOAD;
                end
            end

            // Stream the table out, one slot per cycle while not stalled
            ST_DUMP:
            begin
                if (pend_reg && out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_index_next  = INDEX_W'(k_reg);
                    out_score_next  = rd_data.score;
                    out_tag_next    = rd_data.tag;
                    out_rank_next   = rank_new;
                    out_qual_next   = qual_reg;
                    out_last_next   = (k_reg == LAST_SLOT);
                    prev_score_next = rd_data.score;
                    prev_rank_next  = rank_new;
                    if (k_reg == LAST_SLOT)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ADDR_W'(k_reg + ADDR_W'(1));
                        k_next        = ADDR_W'(k_reg + ADDR_W'(1));
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        score_reg      <= score_next;
        tag_reg        <= tag_next;
        cur_reg        <= cur_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        qual_reg       <= qual_next;
        prev_score_reg <= prev_score_next;
        prev_rank_reg  <= prev_rank_next;
        out_index_reg  <= out_index_next;
        out_score_reg  <= out_score_next;
        out_tag_reg    <= out_tag_next;
        out_rank_reg   <= out_rank_next;
        out_qual_reg   <= out_qual_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_rank_reg, out_tag_reg, out_score_reg, out_index_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_qual_reg;

endmodule

// ===== src/top_k_score_table_insert_rank.sv =====
// Top-k score table: keeps TABLE_DEPTH (score, tag) slots in descending order
// in one RAM. Each request offers a score (saturated at 999999) and a tag; it
// enters the table when it is at least the last slot's score, replacing that
// slot, and the table is re-sorted by an in-place exchange sort in which
// equal scores do swap. Every request then returns the whole table, slot 0
// first, with a competition rank per slot (saturating at 15), the qualified
// flag in tuser and tlast on the final slot. A request is taken only when
// the previous one has been fully streamed into the output register. The
// single read and single write port of the table RAM set the pace: a
// qualifying request is sorted at one compare per cycle, and the dump of
// any request can be held by an output stall. The table needs no clearing
// pass: per-slot valid bits make unwritten slots read as zero. Depends on
// tksr_pkg, tksr_ram and tksr_seq.
module top_k_score_table_insert_rank (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tksr_pkg::IN_TDATA_W-1:0]    s_tdata,  // new_score[19:0], player_tag[51:20]
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tksr_pkg::OUT_TDATA_W-1:0]   m_tdata,  // slot_index[3:0], slot_score[23:4],
                                                         // slot_tag[55:24], slot_rank[59:56]
    output logic                               m_tlast,  // last_slot
    output logic                               m_tuser   // qualified
);
    import tksr_pkg::*;

    mem_req_t               mem_req;
    entry_t                 rd_data;
    logic [ENTRY_W-1:0]     ram_q;
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic                   rvld_reg;

    // Table RAM
    tksr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_q)
    );

    // Per-slot written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.we)
            begin
                vld_reg[mem_req.waddr] <= 1'b1;
            end
            if (mem_req.re)
            begin
                rvld_reg <= vld_reg[mem_req.raddr] ||
                            (mem_req.we && (mem_req.waddr == mem_req.raddr));
            end
        end
    end

    // Unwritten slots read as the reset entry
    assign rd_data = rvld_reg ? entry_t'(ram_q) : '0;

    // Sequencer
    tksr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

endmodule
